FILE: rtl/usd_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
`default_nettype none

package usd_pkg;

	localparam int unsigned CP_W     = 21;
	localparam int unsigned CNT_W    = 3;
	localparam int unsigned DATA_W   = 7;
	localparam int unsigned FQ_DEPTH_DEF = 2;
	localparam int unsigned OQ_DEPTH = 4;
	localparam int unsigned OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int unsigned OQ_CNT_W = $clog2(OQ_DEPTH + 1);

	// Byte classes sorted out by the front end.
	typedef enum logic [3:0] {
		CLS_ASCII,
		CLS_LEAD2,
		CLS_LEAD3,
		CLS_LEAD4,
		CLS_CONT,
		CLS_OVERLONG2,
		CLS_LEAD5,
		CLS_LEAD6,
		CLS_INVALID
	} byte_cls_t;

	typedef struct packed {
		byte_cls_t          cls;
		logic [DATA_W-1:0]  data;
	} fe_entry_t;

	typedef struct packed {
		logic [CP_W-1:0]  code_point;
		logic             error;
		logic [CNT_W-1:0] byte_count;
		logic             last_of_run;
	} result_t;

	// Results handed from the decoder to the output queue in the same cycle.
	typedef struct packed {
		logic [1:0] num;
		result_t    r0;
		result_t    r1;
	} oq_push_t;

endpackage

`default_nettype wire

FILE: rtl/usd_front.sv
// Front end: classifies each incoming byte and queues it for the decoder.
`default_nettype none

module usd_front import usd_pkg::*; #(
	parameter int unsigned FQ_DEPTH = FQ_DEPTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] in_byte,
	input  wire logic       push,
	output logic            full,
	output fe_entry_t       entry,
	output logic            entry_valid,
	input  wire logic       take
);

	localparam int unsigned PTR_W = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
	localparam int unsigned CNT_W_L = $clog2(FQ_DEPTH + 1);

	fe_entry_t           mem_q [FQ_DEPTH];
	logic [PTR_W-1:0]    wr_q;
	logic [PTR_W-1:0]    rd_q;
	logic [CNT_W_L-1:0]  cnt_q;
	fe_entry_t           cls_entry;
	logic                do_push;
	logic                do_pop;

	always_comb begin
		cls_entry.data = in_byte[DATA_W-1:0];
		priority if (in_byte < 8'h80) begin
			cls_entry.cls = CLS_ASCII;
		end else if (in_byte < 8'hC0) begin
			cls_entry.cls = CLS_CONT;
		end else if (in_byte < 8'hC2) begin
			cls_entry.cls = CLS_OVERLONG2;
		end else if (in_byte < 8'hE0) begin
			cls_entry.cls = CLS_LEAD2;
		end else if (in_byte < 8'hF0) begin
			cls_entry.cls = CLS_LEAD3;
		end else if (in_byte < 8'hF8) begin
			cls_entry.cls = CLS_LEAD4;
		end else if (in_byte < 8'hFC) begin
			cls_entry.cls = CLS_LEAD5;
		end else if (in_byte < 8'hFE) begin
			cls_entry.cls = CLS_LEAD6;
		end else begin
			cls_entry.cls = CLS_INVALID;
		end
	end

	assign full        = (cnt_q == CNT_W_L'(FQ_DEPTH));
	assign entry_valid = (cnt_q != '0);
	assign entry       = mem_q[rd_q];
	assign do_push     = push && !full;
	assign do_pop      = take && entry_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(FQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(FQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= cls_entry;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/usd_back.sv
// Back end: sequence state and result generation, up to two results per byte.
`default_nettype none

module usd_back import usd_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  fe_entry_t      entry,
	input  wire logic      entry_valid,
	input  wire logic      room,
	output logic           take,
	output oq_push_t       oq_push
);

	logic [1:0]      pend_q;
	logic [CP_W-1:0] acc_q;
	logic [2:0]      seen_q;
	logic [2:0]      skip_q;

	logic [1:0]      pend_n;
	logic [CP_W-1:0] acc_n;
	logic [2:0]      seen_n;
	logic [2:0]      skip_n;

	// Outcome of treating the entry as the first byte of a character.
	logic            st_emit;
	result_t         st_res;
	logic [1:0]      st_pend;
	logic [CP_W-1:0] st_acc;
	logic [2:0]      st_seen;
	logic [2:0]      st_skip;

	logic [1:0]      cont_pend;
	logic [2:0]      cont_seen;
	logic [CP_W-1:0] cont_acc;
	result_t         err_res;

	assign take = entry_valid && room;

	always_comb begin
		st_emit = 1'b1;
		st_res  = '{code_point: '0, error: 1'b1, byte_count: 3'd1, last_of_run: 1'b1};
		st_pend = '0;
		st_acc  = '0;
		st_seen = '0;
		st_skip = '0;
		unique case (entry.cls)
			CLS_ASCII: begin
				st_res.code_point = CP_W'(entry.data);
				st_res.error      = 1'b0;
			end
			CLS_LEAD2: begin
				st_emit = 1'b0;
				st_pend = 2'd1;
				st_acc  = CP_W'({entry.data[4:0], 6'd0});
				st_seen = 3'd1;
			end
			CLS_LEAD3: begin
				st_emit = 1'b0;
				st_pend = 2'd2;
				st_acc  = CP_W'({entry.data[3:0], 12'd0});
				st_seen = 3'd1;
			end
			CLS_LEAD4: begin
				st_emit = 1'b0;
				st_pend = 2'd3;
				st_acc  = {entry.data[2:0], 18'd0};
				st_seen = 3'd1;
			end
			CLS_OVERLONG2: begin
				st_skip = 3'd1;
				st_res.byte_count = 3'd2;
			end
			CLS_LEAD5: begin
				st_skip = 3'd4;
				st_res.byte_count = 3'd5;
			end
			CLS_LEAD6: begin
				st_skip = 3'd5;
				st_res.byte_count = 3'd6;
			end
			CLS_CONT, CLS_INVALID: begin
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		cont_pend = pend_q - 2'd1;
		cont_seen = seen_q + 3'd1;
		unique case (cont_pend)
			2'd2:    cont_acc = acc_q | CP_W'({entry.data[5:0], 12'd0});
			2'd1:    cont_acc = acc_q | CP_W'({entry.data[5:0], 6'd0});
			default: cont_acc = acc_q | CP_W'(entry.data[5:0]);
		endcase
		err_res = '{code_point: '0, error: 1'b1, byte_count: seen_q, last_of_run: 1'b1};
	end

	always_comb begin
		pend_n      = pend_q;
		acc_n       = acc_q;
		seen_n      = seen_q;
		skip_n      = skip_q;
		oq_push.num = 2'd0;
		oq_push.r0  = st_res;
		oq_push.r1  = st_res;
		if (take) begin
			priority if (skip_q != '0) begin
				skip_n = skip_q - 3'd1;
			end else if (pend_q != '0 && entry.cls == CLS_CONT) begin
				pend_n = cont_pend;
				if (cont_pend == '0) begin
					oq_push.num = 2'd1;
					oq_push.r0  = '{code_point: cont_acc, error: 1'b0,
						byte_count: cont_seen, last_of_run: 1'b1};
					acc_n  = '0;
					seen_n = '0;
				end else begin
					acc_n  = cont_acc;
					seen_n = cont_seen;
				end
			end else if (pend_q != '0) begin
				// Broken sequence: report it, then restart on this same byte.
				pend_n     = st_pend;
				acc_n      = st_acc;
				seen_n     = st_seen;
				skip_n     = st_skip;
				oq_push.r0 = err_res;
				if (st_emit) begin
					oq_push.num = 2'd2;
					oq_push.r0.last_of_run = 1'b0;
				end else begin
					oq_push.num = 2'd1;
				end
			end else begin
				pend_n      = st_pend;
				acc_n       = st_acc;
				seen_n      = st_seen;
				skip_n      = st_skip;
				oq_push.num = st_emit ? 2'd1 : 2'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			acc_q  <= '0;
			seen_q <= '0;
			skip_q <= '0;
		end else begin
			pend_q <= pend_n;
			acc_q  <= acc_n;
			seen_q <= seen_n;
			skip_q <= skip_n;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/usd_outq.sv
// Result queue: takes up to two results per cycle, hands out one per beat.
`default_nettype none

module usd_outq import usd_pkg::*; (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  oq_push_t            oq_push,
	output logic                room,
	output logic                empty,
	input  wire logic           pop,
	output result_t             head
);

	result_t              mem_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0]  wr_q;
	logic [OQ_PTR_W-1:0]  rd_q;
	logic [OQ_CNT_W-1:0]  cnt_q;
	logic                 do_pop;

	// Room for two results, so the decoder never has to split a byte's output.
	assign room   = (cnt_q <= OQ_CNT_W'(OQ_DEPTH - 2));
	assign empty  = (cnt_q == '0);
	assign head   = mem_q[rd_q];
	assign do_pop = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + OQ_PTR_W'(oq_push.num);
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + OQ_CNT_W'(oq_push.num) - OQ_CNT_W'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (oq_push.num != 2'd0) begin
			mem_q[wr_q] <= oq_push.r0;
		end
		if (oq_push.num == 2'd2) begin
			mem_q[wr_q + 1'b1] <= oq_push.r1;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/utf8_stream_decoder_core.sv
// Top level of the UTF-8 stream decoder: front queue, decoder and result queue.
// Throughput: one byte per cycle while the result queue has room; a byte may yield
// two results, drained one per beat, and written to the result queue as it is taken.
// The front queue holds FQ_DEPTH bytes; the result queue holds four results.
// Reset (arst_n low, asynchronous) empties both queues and returns the decoder to idle.
`default_nettype none

module utf8_stream_decoder_core import usd_pkg::*; #(
	parameter int unsigned FQ_DEPTH = FQ_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [7:0]        in_byte,
	input  wire logic              push,
	output logic                   full,
	output logic [CP_W-1:0]        code_point,
	output logic                   error,
	output logic [CNT_W-1:0]       byte_count,
	output logic                   last_of_run,
	output logic                   empty,
	input  wire logic              pop
);

	fe_entry_t entry;
	logic      entry_valid;
	logic      take;
	logic      room;
	oq_push_t  oq_push;
	result_t   head;

	usd_front #(
		.FQ_DEPTH(FQ_DEPTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_byte     (in_byte),
		.push        (push),
		.full        (full),
		.entry       (entry),
		.entry_valid (entry_valid),
		.take        (take)
	);

	usd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.entry       (entry),
		.entry_valid (entry_valid),
		.room        (room),
		.take        (take),
		.oq_push     (oq_push)
	);

	usd_outq u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.oq_push (oq_push),
		.room    (room),
		.empty   (empty),
		.pop     (pop),
		.head    (head)
	);

	assign code_point  = head.code_point;
	assign error       = head.error;
	assign byte_count  = head.byte_count;
	assign last_of_run = head.last_of_run;

endmodule

`default_nettype wire
